[design/snr_pkg.sv]
// Shared types and constants for the service name registry.
`timescale 1ns / 1ps
`default_nettype none

package snr_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned NAME_BYTES    = 8;

  // Field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned NAME_W  = NAME_BYTES * 8;
  localparam int unsigned ENTRY_W = NAME_W + ID_W;
  localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(TABLE_ENTRIES + 1);

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 3'd0,
    OP_FIND_NAME  = 3'd1,
    OP_FIND_ID    = 3'd2,
    OP_MARK_READY = 3'd3,
    OP_UNREGISTER = 3'd4
  } snr_op_e;

  // Entry status codes
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_BUSY  = 2'd1,
    ST_READY = 2'd2
  } snr_status_e;

  // Compare unit result for one entry
  typedef struct packed {
    logic hit;
    logic is_free;
  } snr_match_t;

endpackage

`default_nettype wire

[design/snr_if.sv]
// Request and response channel interfaces of the service name registry.
`timescale 1ns / 1ps
`default_nettype none

interface snr_req_if import snr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  name_key;
  logic [ID_W-1:0]   proc_id;
  logic              caller_unprivileged;

  modport source (output valid, output op, output name_key, output proc_id,
                  output caller_unprivileged, input ready);
  modport sink   (input valid, input op, input name_key, input proc_id,
                  input caller_unprivileged, output ready);
endinterface

interface snr_rsp_if import snr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            ok;
  logic [ID_W-1:0] found_id;

  modport source (output valid, output ok, output found_id, input ready);
  modport sink   (input valid, input ok, input found_id, output ready);
endinterface

`default_nettype wire

[design/snr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module snr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/snr_match.sv]
// Shared entry compare unit: tests one table entry against the current request.
`timescale 1ns / 1ps
`default_nettype none

module snr_match import snr_pkg::*; (
  input  snr_op_e           op_i,
  input  logic [NAME_W-1:0] key_i,
  input  logic [ID_W-1:0]   id_i,
  input  logic [NAME_W-1:0] name_i,
  input  logic [ID_W-1:0]   owner_i,
  input  snr_status_e       status_i,
  output snr_match_t        res_o
);

  logic occupied;
  logic ready;
  logic name_eq;
  logic owner_eq;

  assign occupied = (status_i != ST_FREE);
  assign ready    = (status_i == ST_READY);
  assign name_eq  = (name_i == key_i);
  assign owner_eq = (owner_i == id_i);

  // Select the match rule of the operation
  always_comb begin
    res_o.is_free = !occupied;
    case (op_i)
      OP_REGISTER:   res_o.hit = occupied && name_eq;
      OP_FIND_NAME:  res_o.hit = ready && name_eq;
      OP_FIND_ID:    res_o.hit = ready && owner_eq;
      OP_MARK_READY: res_o.hit = occupied && owner_eq;
      OP_UNREGISTER: res_o.hit = occupied && owner_eq;
      default:       res_o.hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[design/service_name_registry.sv]
// Service name registry top level: sequencer, entry table and response register.
//
// Requests arrive on req_i (valid/ready); each carries an operation, a name key,
// a process id and the caller privilege flag. Every request yields exactly one
// response word on rsp_o: ok and the found process id.
// One request is in work at a time. After a request word is accepted, the
// sequencer reads the entry table one entry per cycle through the RAM read port
// and feeds each entry to the single compare unit, recording the first match
// and the first free entry. After the scan, a commit state updates the table
// and loads the response register. The next request can be accepted only after
// the response has been taken, so the sustained request rate is set by the
// one-entry-per-cycle scan.
// req_i.ready is high only while the block is idle.
// Reset empties the table at once: entry status lives in flip-flops that reset
// clears, and name and owner of a free entry are never used.
// A stalled response holds in its output register; no new request is taken
// until the response word has been accepted.
`timescale 1ns / 1ps
`default_nettype none

module service_name_registry import snr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  snr_req_if.sink    req_i,
  snr_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;

  snr_op_e           op_q;
  logic [NAME_W-1:0] key_q;
  logic [ID_W-1:0]   id_q;
  logic              unpriv_q;

  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [ID_W-1:0]   hit_owner_q;
  logic              free_q;
  logic [IDX_W-1:0]  free_idx_q;

  snr_status_e       status_q [TABLE_ENTRIES];

  logic              rsp_vld_q;
  logic              ok_q;
  logic [ID_W-1:0]   fid_q;

  logic               ram_we;
  logic [IDX_W-1:0]   tgt_idx;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               commit_ok;
  logic               commit_wr;
  logic               st_we;
  snr_status_e        new_status;
  logic [ID_W-1:0]    commit_fid;

  snr_match_t         match;

  // Scan read: one entry per cycle
  assign ram_re    = (state_q == S_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));
  assign ram_raddr = cnt_q[IDX_W-1:0];

  snr_ram #(
    .Width (ENTRY_W),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  snr_match u_match (
    .op_i     (op_q),
    .key_i    (key_q),
    .id_i     (id_q),
    .name_i   (ram_rdata[ENTRY_W-1:ID_W]),
    .owner_i  (ram_rdata[ID_W-1:0]),
    .status_i (status_q[cmp_idx_q]),
    .res_o    (match)
  );

  // Decide the table update and the response of the commit cycle
  always_comb begin
    tgt_idx    = hit_q ? hit_idx_q : free_idx_q;
    commit_ok  = 1'b0;
    commit_wr  = 1'b0;
    st_we      = 1'b0;
    new_status = ST_FREE;
    ram_wdata  = '0;
    commit_fid = '0;
    case (op_q)
      OP_REGISTER: begin
        commit_ok  = !unpriv_q && (hit_q || free_q);
        commit_wr  = commit_ok;
        st_we      = commit_ok;
        new_status = ST_BUSY;
        ram_wdata  = {key_q, id_q};
      end
      OP_FIND_NAME, OP_FIND_ID: begin
        commit_ok  = hit_q;
        commit_fid = hit_q ? hit_owner_q : '0;
      end
      OP_MARK_READY: begin
        commit_ok  = hit_q;
        st_we      = hit_q;
        new_status = ST_READY;
      end
      OP_UNREGISTER: begin
        commit_ok  = hit_q;
        commit_wr  = hit_q;
        st_we      = hit_q;
        new_status = ST_FREE;
      end
      default: begin
        commit_ok = 1'b0;
      end
    endcase
    ram_we = (state_q == S_COMMIT) && commit_wr;
  end

  // Sequencer, scan bookkeeping, entry status and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      op_q        <= OP_REGISTER;
      key_q       <= '0;
      id_q        <= '0;
      unpriv_q    <= 1'b0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_owner_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      rsp_vld_q   <= 1'b0;
      ok_q        <= 1'b0;
      fid_q       <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      cmp_vld_q <= ram_re;
      cmp_idx_q <= ram_raddr;

      // Keep the first matching and the first free entry
      if (cmp_vld_q) begin
        if (match.hit && !hit_q) begin
          hit_q       <= 1'b1;
          hit_idx_q   <= cmp_idx_q;
          hit_owner_q <= ram_rdata[ID_W-1:0];
        end
        if (match.is_free && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q     <= snr_op_e'(req_i.op);
            key_q    <= req_i.name_key[NAME_W-1:0];
            id_q     <= req_i.proc_id;
            unpriv_q <= req_i.caller_unprivileged;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            cnt_q    <= '0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
            state_q <= S_COMMIT;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_COMMIT: begin
          if (st_we) begin
            status_q[tgt_idx] <= new_status;
          end
          rsp_vld_q <= 1'b1;
          ok_q      <= commit_ok;
          fid_q     <= commit_fid;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (rsp_o.ready) begin
            rsp_vld_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = rsp_vld_q;
  assign rsp_o.ok       = ok_q;
  assign rsp_o.found_id = fid_q;

`ifndef SYNTHESIS
  // An accepted request starts the scan at the first entry
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_SCAN && cnt_q == '0))
    else $error("scan did not start after request");

  // A nonzero id is returned only by a successful lookup
  a_fid_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && fid_q != '0) |->
      (ok_q && (op_q == OP_FIND_NAME || op_q == OP_FIND_ID)))
    else $error("found id on a non-lookup or failed response");

  // Compares happen only during the scan
  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == S_SCAN))
    else $error("entry compare outside the scan");

  // No new request while a response is pending
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> !req_i.ready)
    else $error("request taken while response pending");
`endif

endmodule

`default_nettype wire
